// ----- design/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// Merge sort engine package
// Shared constants and types for the sorting cell chain and its control.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

    localparam int MAX_ITEMS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ----- design/mse_cell.sv -----
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one element of the ordered chain; takes part in ordered insertion and
// shifts towards the head of the chain during readout.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_cell #(
    parameter int VALUE_BITS = mse_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mse_pkg::t_cell_ctrl          i_ctrl,
    input  wire logic signed [VALUE_BITS-1:0] i_new,
    input  wire logic                         i_left_take,
    input  wire logic                         i_left_full,
    input  wire logic signed [VALUE_BITS-1:0] i_left_val,
    input  wire logic                         i_right_full,
    input  wire logic signed [VALUE_BITS-1:0] i_right_val,
    output logic                              o_take,
    output logic                              o_full,
    output logic signed [VALUE_BITS-1:0]      o_val
);

    logic signed [VALUE_BITS-1:0] r_val;
    logic                         r_full;

    // An empty cell acts as positive infinity, so the taking cells form a suffix.
    assign o_take = !r_full || (i_new < r_val);
    assign o_full = r_full;
    assign o_val  = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_full <= i_right_full;
        end else if (i_ctrl.insert && o_take) begin
            r_full <= r_full | i_left_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_val <= i_right_val;
        end else if (i_ctrl.insert && o_take) begin
            r_val <= i_left_take ? i_left_val : i_new;
        end
    end

endmodule

`default_nettype wire

// ----- design/merge_sort_engine.sv -----
// ----------------------------------------------------------------------------
// Merge sort engine
// Collects a set of signed values in an ordered chain of cells and emits them
// in ascending order once the closing transaction has arrived.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  input   | in        | i_in_valid / o_in_stall | i_value, i_last_item
//  output  | out       | o_out_valid / i_out_stall | o_sorted_value, o_last_result,
//          |           |                         | o_overflow
//
// Each accepted input transaction is inserted into the cell chain while it has room.
// After the closing transaction the chain shifts one element per cycle into the output
// register while the output is not stalled; input is stalled during readout.
// Reset empties the chain. Output stalls hold the chain in place.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sort_engine #(
    parameter int MAX_ITEMS  = mse_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = mse_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire logic                         i_last_item,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [VALUE_BITS-1:0]      o_sorted_value,
    output logic                              o_last_result,
    output logic                              o_overflow
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    mse_pkg::t_state              r_state;
    logic [CW-1:0]                r_count;
    logic                         r_ovf;
    logic                         r_out_vld;
    logic signed [VALUE_BITS-1:0] r_out_val;
    logic                         r_out_last;
    logic                         r_out_ovf;

    logic                         in_acc;
    logic                         emit;
    mse_pkg::t_cell_ctrl          ctrl;

    logic                         take [MAX_ITEMS];
    logic                         full [MAX_ITEMS];
    logic signed [VALUE_BITS-1:0] val  [MAX_ITEMS];

    assign o_in_stall = (r_state != mse_pkg::ST_LOAD);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign emit       = (r_state == mse_pkg::ST_DRAIN) && (!r_out_vld || !i_out_stall);

    assign ctrl.insert = in_acc && (r_count != CW'(MAX_ITEMS));
    assign ctrl.shift  = emit;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic                         left_take;
        logic                         left_full;
        logic signed [VALUE_BITS-1:0] left_val;
        logic                         right_full;
        logic signed [VALUE_BITS-1:0] right_val;

        if (g == 0) begin : g_head
            assign left_take = 1'b0;
            assign left_full = 1'b1;
            assign left_val  = '0;
        end else begin : g_body
            assign left_take = take[g-1];
            assign left_full = full[g-1];
            assign left_val  = val[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign right_full = 1'b0;
            assign right_val  = '0;
        end else begin : g_inner
            assign right_full = full[g+1];
            assign right_val  = val[g+1];
        end

        mse_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_new       (i_value),
            .i_left_take (left_take),
            .i_left_full (left_full),
            .i_left_val  (left_val),
            .i_right_full(right_full),
            .i_right_val (right_val),
            .o_take      (take[g]),
            .o_full      (full[g]),
            .o_val       (val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mse_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                mse_pkg::ST_LOAD: begin
                    if (in_acc) begin
                        if (ctrl.insert) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_item) begin
                            r_state <= mse_pkg::ST_DRAIN;
                        end
                    end
                end
                mse_pkg::ST_DRAIN: begin
                    if (emit) begin
                        r_count <= r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            r_state <= mse_pkg::ST_LOAD;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= mse_pkg::ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_val  <= val[0];
            r_out_last <= (r_count == CW'(1));
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_sorted_value = r_out_val;
    assign o_last_result  = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

`default_nettype wire

// ----- design/mse_checker.sv -----
// ----------------------------------------------------------------------------
// Merge sort engine checker
// Port-level checks on ordering, readout and handshake behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_checker #(
    parameter int VALUE_BITS = mse_pkg::VALUE_BITS_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         i_last_item,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic signed [VALUE_BITS-1:0] o_sorted_value,
    input wire logic                         o_last_result,
    input wire logic                         o_overflow
);

    logic                         r_open;
    logic signed [VALUE_BITS-1:0] r_prev;
    logic                         r_prev_ovf;
    logic                         out_acc;

    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (out_acc) begin
            r_open <= !o_last_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev     <= o_sorted_value;
            r_prev_ovf <= o_overflow;
        end
    end

    // Within a set the results never decrease.
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_open |-> o_sorted_value >= r_prev)
        else $error("sorted output decreased within a set");

    // The overflow mark is the same on every result of a set.
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_open |-> o_overflow == r_prev_ovf)
        else $error("overflow mark changed within a set");

    // A closing transaction starts readout, which stalls the input side.
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_item |=> o_in_stall)
        else $error("input not stalled after closing transaction");

    // A result other than the last one is only offered while readout continues.
    a_mid_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_result |-> o_in_stall)
        else $error("non-final result while input accepted");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sorted_value))
        else $error("stalled result changed");

endmodule

bind merge_sort_engine mse_checker #(
    .VALUE_BITS(VALUE_BITS)
) u_mse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_last_item   (i_last_item),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_sorted_value(o_sorted_value),
    .o_last_result (o_last_result),
    .o_overflow    (o_overflow)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Merge sort engine testbench
// Sends sets of signed values to the sort engine and checks that each set is
// returned in ascending order, with the final mark and the overflow flag.
// A short table of hand-picked sets comes first, then random sets. Both
// sides idle at random, and once the output is held off long enough for the
// engine to stall its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_ITEMS  = mse_pkg::MAX_ITEMS_DEF;
    localparam int VALUE_BITS = mse_pkg::VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS = 176;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    typedef struct {
        t_value value;
        logic   last;
        logic   overflow;
    } t_sorted_result;

    typedef struct {
        t_value first;
        int     step;
        int     reps;
        logic   last;
        bit     typed;
    } t_stim_row;

    localparam t_value VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam t_value VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    t_value i_value = '0;
    logic   i_last_item = 1'b0;
    logic   i_out_stall = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_value o_sorted_value;
    logic   o_last_result;
    logic   o_overflow;

    logic   hold_off = 1'b0;
    bit     random_phase = 1'b0;
    int     error_count = 0;
    int     burst_left = 1;

    t_value         pending_set[$];
    logic           set_overflowed = 1'b0;
    t_sorted_result sorted_expect[$];

    t_stim_row directed_rows[15] = '{
        '{VAL_MIN, 0, 1, 1'b1, 1'b1},
        '{VAL_MAX, 0, 1, 1'b1, 1'b1},
        '{0, 0, 1, 1'b1, 1'b1},
        '{-1, 0, 1, 1'b1, 1'b1},
        '{VAL_MAX, 0, 1, 1'b0, 1'b0},
        '{VAL_MIN, 0, 1, 1'b0, 1'b0},
        '{1, 0, 1, 1'b0, 1'b0},
        '{-1, 0, 1, 1'b1, 1'b0},
        '{32'h5555_5555, 0, 1, 1'b0, 1'b0},
        '{32'hAAAA_AAAA, 0, 1, 1'b1, 1'b0},
        '{7, 0, 3, 1'b1, 1'b0},
        '{100, -1, 10, 1'b1, 1'b0},
        '{-50, 1, MAX_ITEMS, 1'b1, 1'b0},
        '{1000, -3, MAX_ITEMS + 1, 1'b1, 1'b0},
        '{42, 0, 1, 1'b1, 1'b1}
    };

    merge_sort_engine u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_last_item    (i_last_item),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_result  (o_last_result),
        .o_overflow     (o_overflow)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void predict_sorted_set(t_value v, logic closes);
        t_value         ordered[$];
        int             pos;
        t_sorted_result res;
        if (pending_set.size() < MAX_ITEMS) begin
            pending_set.push_back(v);
        end else begin
            set_overflowed = 1'b1;
        end
        if (closes) begin
            foreach (pending_set[i]) begin
                pos = 0;
                while (pos < ordered.size() && ordered[pos] <= pending_set[i]) pos++;
                ordered.insert(pos, pending_set[i]);
            end
            foreach (ordered[i]) begin
                res.value    = ordered[i];
                res.last     = (i == ordered.size() - 1);
                res.overflow = set_overflowed;
                sorted_expect.push_back(res);
            end
            pending_set.delete();
            set_overflowed = 1'b0;
        end
    endfunction

    function automatic t_value pick_value(int style, t_value base, int k);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 6)) - 3;
            2: begin
                case ($urandom_range(0, 4))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return base - k;
        endcase
    endfunction

    task automatic offer_element(t_value v, logic closes, bit typed);
        t_sorted_result res;
        int             gap;
        i_in_valid  <= 1'b1;
        i_value     <= v;
        i_last_item <= closes;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (typed) begin
            res.value    = v;
            res.last     = 1'b1;
            res.overflow = 1'b0;
            sorted_expect.push_back(res);
        end else begin
            predict_sorted_set(v, closes);
        end
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic check_result();
        t_sorted_result exp_res;
        if (sorted_expect.size() == 0) begin
            $display("%0t: unexpected result %0d", $time, o_sorted_value);
            error_count++;
        end else begin
            exp_res = sorted_expect.pop_front();
            if (o_sorted_value !== exp_res.value) begin
                $display("%0t: sorted_value expected %0d, got %0d",
                         $time, exp_res.value, o_sorted_value);
                error_count++;
            end
            if (o_last_result !== exp_res.last) begin
                $display("%0t: last_result expected %0b, got %0b",
                         $time, exp_res.last, o_last_result);
                error_count++;
            end
            if (o_overflow !== exp_res.overflow) begin
                $display("%0t: overflow expected %0b, got %0b",
                         $time, exp_res.overflow, o_overflow);
                error_count++;
            end
        end
    endtask

    initial begin : output_side
        int  cycle_idx;
        int  style;
        logic stall_next;
        cycle_idx = 0;
        style = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_result();
            cycle_idx++;
            if (cycle_idx % 48 == 0) style = $urandom_range(0, 3);
            case (style)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = (cycle_idx % 5 < 2);
                default: stall_next = ($urandom_range(0, 9) < 7);
            endcase
            i_out_stall <= stall_next || hold_off;
        end
    end

    initial begin : output_hold_off
        wait (random_phase);
        repeat ($urandom_range(50, 200)) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : input_side
        int     items_sent;
        int     set_size;
        int     style;
        int     pick;
        t_value base;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                offer_element(directed_rows[r].first + k * directed_rows[r].step,
                              directed_rows[r].last && (k == directed_rows[r].reps - 1),
                              directed_rows[r].typed);
            end
        end

        random_phase = 1'b1;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                set_size = $urandom_range(1, 8);
            end else if (pick < 90) begin
                set_size = $urandom_range(9, 40);
            end else if (pick < 96) begin
                set_size = $urandom_range(41, MAX_ITEMS);
            end else begin
                set_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            end
            style = $urandom_range(0, 3);
            base = $urandom;
            for (int k = 0; k < set_size; k++) begin
                offer_element(pick_value(style, base, k), k == set_size - 1, 1'b0);
                items_sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (sorted_expect.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_ITEMS) @(posedge i_clk);
        if (error_count == 0 && sorted_expect.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
